// ===== design/sbpt_pkg.sv =====
package sbpt_pkg;

  // Sizing of the sieve and of the stored prime list.
  localparam int SIEVE_LIMIT = 10000;
  localparam int PRIME_COUNT = 1229;
  localparam int FLAG_DEPTH  = SIEVE_LIMIT + 1;

  // Field widths.
  localparam int VALUE_W = 27;
  localparam int TOTAL_W = 24;

  // Derived widths.
  localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
  localparam int PRIME_W    = FLAG_AW;
  localparam int IDX_W      = $clog2(PRIME_COUNT);
  localparam int CNT_W      = $clog2(PRIME_COUNT + 1);
  localparam int SQ_W       = 2 * PRIME_W;
  localparam int CMP_W      = (SQ_W > VALUE_W) ? SQ_W : VALUE_W;
  localparam int DIV_CNT_W  = $clog2(VALUE_W);

  localparam logic [TOTAL_W-1:0] TALLY_MAX = '1;

  typedef enum logic [2:0] {
    SV_INIT,
    SV_READ,
    SV_CHECK,
    SV_MARK,
    SV_DONE
  } sieve_state_t;

  typedef enum logic [2:0] {
    TS_SIEVE,
    TS_IDLE,
    TS_LOOK,
    TS_FETCH,
    TS_SQUARE,
    TS_DECIDE,
    TS_DIV,
    TS_RESULT
  } test_state_t;

  typedef struct packed {
    logic             ready;
    logic [CNT_W-1:0] count;
  } sieve_status_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

// ===== design/sieve_backed_primality_tester_core.sv =====
// Steps: a value below the sieve limit is decided by a flag-table lookup once it is accepted.
// A larger value is tried against each stored prime in turn (fetch, square, compare and
// a bit-serial remainder), over at most 1229 primes.
// Throughput: one item at a time; the next item is taken while a result still waits.
// Reset: synchronous, active low; the sieve then runs its passes before the
// first item is taken.
module sieve_backed_primality_tester_core
  import sbpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_prime,
  output logic [TOTAL_W-1:0] out_prime_total
);

  // The sieve module owns the flag table and the prime list. Once its sweep
  // and marking passes are over, its read ports serve the item logic here.
  test_state_t        state_r, state_nxt;
  logic [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]   k_r;
  logic [SQ_W-1:0]    sq_r;
  logic               verdict_r;
  logic [TOTAL_W-1:0] tally_r;
  logic [TOTAL_W-1:0] tally_nxt;
  logic               out_valid_r;
  logic               out_is_prime_r;
  logic [TOTAL_W-1:0] out_total_r;

  sieve_status_t      sv_status;
  div_status_t        dv_status;
  logic               flag_rdata;
  logic [FLAG_AW-1:0] flag_raddr;
  logic [PRIME_W-1:0] list_rdata;

  logic               in_accept;
  logic               is_small;
  logic               list_end;
  logic               sq_above;
  logic               div_start;
  logic               out_load;
  logic [CMP_W-1:0]   sq_cmp;
  logic [CMP_W-1:0]   val_cmp;

  // While idle the flag table is addressed straight from the input port, so
  // that the flag for an accepted small value is ready in the cycle after it is accepted.
  assign flag_raddr = (state_r == TS_IDLE) ? in_value[FLAG_AW-1:0] : value_r[FLAG_AW-1:0];

  sbpt_sieve u_sieve (
    .clk        (clk),
    .rst_n      (rst_n),
    .flag_raddr (flag_raddr),
    .flag_rdata (flag_rdata),
    .list_raddr (k_r[IDX_W-1:0]),
    .list_rdata (list_rdata),
    .status     (sv_status)
  );

  sbpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (value_r),
    .divisor  (list_rdata),
    .status   (dv_status)
  );

  assign in_accept = in_valid && in_ready;
  assign is_small  = (in_value < VALUE_W'(SIEVE_LIMIT));
  assign list_end  = (k_r == sv_status.count);
  assign sq_cmp    = CMP_W'(sq_r);
  assign val_cmp   = CMP_W'(value_r);
  assign sq_above  = (sq_cmp > val_cmp);
  assign out_load  = (state_r == TS_RESULT) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TS_SIEVE: begin
        if (sv_status.ready) state_nxt = TS_IDLE;
      end
      TS_IDLE: begin
        if (in_accept) state_nxt = is_small ? TS_LOOK : TS_FETCH;
      end
      TS_LOOK: state_nxt = TS_RESULT;
      TS_FETCH: begin
        state_nxt = list_end ? TS_RESULT : TS_SQUARE;
      end
      TS_SQUARE: state_nxt = TS_DECIDE;
      TS_DECIDE: begin
        state_nxt = sq_above ? TS_RESULT : TS_DIV;
      end
      TS_DIV: begin
        if (dv_status.done) state_nxt = dv_status.rem_zero ? TS_RESULT : TS_FETCH;
      end
      TS_RESULT: begin
        if (out_load) state_nxt = TS_IDLE;
      end
      default: state_nxt = TS_SIEVE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      TS_IDLE:   in_ready  = 1'b1;
      TS_DECIDE: div_start = !sq_above;
      default:   in_ready  = 1'b0;
    endcase
  end

  // The tally saturates at its all-ones value.
  assign tally_nxt = (verdict_r && (tally_r != TALLY_MAX)) ? tally_r + 1'b1 : tally_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_SIEVE;
      k_r         <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) k_r <= '0;
      else if ((state_r == TS_DIV) && dv_status.done && !dv_status.rem_zero) k_r <= k_r + 1'b1;
      if (out_load) begin
        tally_r     <= tally_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item data and the verdict; the verdict is only read in the result state.
  always_ff @(posedge clk) begin
    if (in_accept) value_r <= in_value;
    if (state_r == TS_SQUARE) sq_r <= SQ_W'(list_rdata) * SQ_W'(list_rdata);
    unique case (state_r)
      TS_LOOK:   verdict_r <= flag_rdata;
      TS_FETCH:  if (list_end) verdict_r <= 1'b1;
      TS_DECIDE: if (sq_above) verdict_r <= 1'b1;
      TS_DIV:    if (dv_status.done && dv_status.rem_zero) verdict_r <= 1'b0;
      default:   verdict_r <= verdict_r;
    endcase
    if (out_load) begin
      out_is_prime_r <= verdict_r;
      out_total_r    <= tally_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_prime    = out_is_prime_r;
  assign out_prime_total = out_total_r;

endmodule

// ===== design/sbpt_sieve.sv =====
module sbpt_sieve
  import sbpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FLAG_AW-1:0]  flag_raddr,
  output logic                flag_rdata,
  input  logic [IDX_W-1:0]    list_raddr,
  output logic [PRIME_W-1:0]  list_rdata,
  output sieve_status_t       status
);

  sieve_state_t       state_r, state_nxt;
  logic [FLAG_AW-1:0] n_r;
  logic [FLAG_AW-1:0] m_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               flag_mem [FLAG_DEPTH];
  logic [PRIME_W-1:0] list_mem [PRIME_COUNT];
  logic               flag_rd_r;
  logic [PRIME_W-1:0] list_rd_r;

  logic               flag_we;
  logic [FLAG_AW-1:0] flag_waddr;
  logic               flag_wdata;
  logic               list_we;
  logic [FLAG_AW-1:0] flag_rd_addr;

  logic [FLAG_AW:0]   step_sum;
  logic [FLAG_AW:0]   dbl;
  logic [FLAG_AW:0]   limit_x;
  logic               n_last;
  logic               do_mark;

  assign limit_x  = (FLAG_AW + 1)'(SIEVE_LIMIT);
  assign step_sum = {1'b0, m_r} + {1'b0, n_r};
  assign dbl      = {n_r, 1'b0};
  assign n_last   = (n_r == FLAG_AW'(SIEVE_LIMIT));
  assign do_mark  = flag_rd_r && (dbl <= limit_x);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SV_INIT: begin
        if (m_r == FLAG_AW'(SIEVE_LIMIT)) state_nxt = SV_READ;
      end
      SV_READ: state_nxt = SV_CHECK;
      SV_CHECK: begin
        if (do_mark) state_nxt = SV_MARK;
        else if (n_last) state_nxt = SV_DONE;
        else state_nxt = SV_READ;
      end
      SV_MARK: begin
        if (step_sum > limit_x) state_nxt = n_last ? SV_DONE : SV_READ;
      end
      SV_DONE: state_nxt = SV_DONE;
      default: state_nxt = SV_INIT;
    endcase
  end

  // Memory controls.
  always_comb begin
    flag_we      = 1'b0;
    flag_waddr   = m_r;
    flag_wdata   = 1'b0;
    list_we      = 1'b0;
    flag_rd_addr = n_r;
    unique case (state_r)
      SV_INIT: begin
        flag_we    = 1'b1;
        flag_wdata = (m_r >= FLAG_AW'(2));
      end
      SV_CHECK: begin
        list_we = flag_rd_r && (cnt_r < CNT_W'(PRIME_COUNT));
      end
      SV_MARK: begin
        flag_we = 1'b1;
      end
      SV_DONE: begin
        flag_rd_addr = flag_raddr;
      end
      default: begin
        flag_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SV_INIT;
      n_r     <= FLAG_AW'(2);
      m_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        SV_INIT: begin
          m_r <= m_r + 1'b1;
          n_r <= FLAG_AW'(2);
        end
        SV_CHECK: begin
          if (list_we) cnt_r <= cnt_r + 1'b1;
          m_r <= dbl[FLAG_AW-1:0];
          if (!do_mark) n_r <= n_r + 1'b1;
        end
        SV_MARK: begin
          m_r <= step_sum[FLAG_AW-1:0];
          if (step_sum > limit_x) n_r <= n_r + 1'b1;
        end
        default: begin
          m_r <= m_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    flag_rd_r <= flag_mem[flag_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[cnt_r[IDX_W-1:0]] <= n_r[PRIME_W-1:0];
    list_rd_r <= list_mem[list_raddr];
  end

  assign flag_rdata   = flag_rd_r;
  assign list_rdata   = list_rd_r;
  assign status.ready = (state_r == SV_DONE);
  assign status.count = cnt_r;

endmodule

// ===== design/sbpt_div.sv =====
module sbpt_div
  import sbpt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [PRIME_W-1:0] divisor,
  output div_status_t        status
);

  // Restoring remainder, one dividend bit per cycle, most significant first.
  logic                 busy_r;
  logic                 done_r;
  logic [VALUE_W-1:0]   dvd_r;
  logic [PRIME_W-1:0]   dsr_r;
  logic [PRIME_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] bit_cnt_r;

  logic [PRIME_W:0]     trial;
  logic [PRIME_W:0]     dsr_x;
  logic [PRIME_W:0]     diff;
  logic [PRIME_W-1:0]   rem_nxt;

  assign trial   = {rem_r, dvd_r[VALUE_W-1]};
  assign dsr_x   = {1'b0, dsr_r};
  assign diff    = trial - dsr_x;
  assign rem_nxt = (trial >= dsr_x) ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= '0;
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
        if (bit_cnt_r == DIV_CNT_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[VALUE_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import sbpt_pkg::*;
();

  // The slowest correct item is a large prime that walks the whole stored list. Allow for
  // that on every item, plus both sides' idle draws, the long receiver hold-off and the
  // sieve pass after reset, then take it three times over.
  localparam int NUM_RANDOM  = 120;
  localparam int NUM_ROWS    = 20;
  localparam int HOLD_OFF    = 400;
  localparam int HOLD_AT     = 2;
  localparam int DRAIN       = 64;
  localparam int CYCLE_LIMIT =
    3 * (60_000 + HOLD_OFF + (NUM_ROWS + NUM_RANDOM) * (PRIME_COUNT * 31 + 1_000 + 40));

  typedef struct packed {
    logic               is_prime;
    logic [TOTAL_W-1:0] total;
  } verdict_t;

  // One row of the directed table. Where typed is set, the expected verdict is written out
  // in the row; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic               is_prime;
    logic [TOTAL_W-1:0] total;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // Straight after reset the tally starts from zero, so these totals can be typed in.
    '{27'd0,         1'b1, 1'b0, 24'd0},   // zero is not prime
    '{27'd1,         1'b1, 1'b0, 24'd0},   // one is not prime
    '{27'd2,         1'b1, 1'b1, 24'd1},   // smallest prime
    '{27'd3,         1'b1, 1'b1, 24'd2},
    '{27'd4,         1'b1, 1'b0, 24'd2},
    '{27'd9973,      1'b1, 1'b1, 24'd3},   // largest prime in the flag table
    '{27'd9999,      1'b1, 1'b0, 24'd3},   // last value decided by lookup
    '{27'd10000,     1'b1, 1'b0, 24'd3},   // the sieve limit itself goes to trial division
    '{27'd10007,     1'b1, 1'b1, 24'd4},   // first prime above the limit
    '{27'h7FFFFFF,   1'b1, 1'b0, 24'd4},   // all ones, 7 divides it
    // From here the predictor supplies the verdict.
    '{27'd9409,      1'b0, 1'b0, 24'd0},   // square of 97, still a lookup
    '{27'd10201,     1'b0, 1'b0, 24'd0},   // square of 101, caught only by the inclusive stop
    '{27'd49,        1'b0, 1'b0, 24'd0},
    '{27'd65536,     1'b0, 1'b0, 24'd0},
    '{27'd67108864,  1'b0, 1'b0, 24'd0},   // top bit alone
    '{27'h2AAAAAA,   1'b0, 1'b0, 24'd0},
    '{27'h5555555,   1'b0, 1'b0, 24'd0},
    '{27'd99460729,  1'b0, 1'b0, 24'd0},   // square of the largest stored prime
    '{27'd99999989,  1'b0, 1'b0, 24'd0},   // largest prime below 100,000,000, walks the whole list
    '{27'd100140049, 1'b0, 1'b0, 24'd0}    // square of 10007: the list runs out, so prime
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_is_prime;
  logic [TOTAL_W-1:0] out_prime_total;

  // Predictor state: its own sieve, stored primes and running tally.
  bit                 small_flags [0:SIEVE_LIMIT];
  int unsigned        stored_primes [PRIME_COUNT];
  int unsigned        stored_count;
  logic [TOTAL_W-1:0] prime_tally = '0;

  verdict_t pending_verdicts [$];
  int       mismatches = 0;
  int       cycle_count = 0;

  sieve_backed_primality_tester_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_prime    (out_is_prime),
    .out_prime_total (out_prime_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sieve of Eratosthenes over 0..SIEVE_LIMIT, keeping at most PRIME_COUNT primes.
  initial begin
    int unsigned n;
    int unsigned m;
    stored_count = 0;
    for (n = 0; n <= SIEVE_LIMIT; n++) small_flags[n] = (n >= 2);
    for (n = 2; n <= SIEVE_LIMIT; n++) begin
      if (small_flags[n]) begin
        if (stored_count < PRIME_COUNT) begin
          stored_primes[stored_count] = n;
          stored_count++;
        end
        for (m = 2 * n; m <= SIEVE_LIMIT; m += n) small_flags[m] = 1'b0;
      end
    end
  end

  // Works out the verdict for one accepted value and advances the saturating tally.
  // Below the limit the flag table decides; at or above it, trial division from 2 stops with
  // prime once a stored prime's square exceeds the value, and a value with no stored
  // factor is taken as prime.
  function automatic verdict_t predict_primality(input logic [VALUE_W-1:0] value);
    verdict_t          verdict;
    longint unsigned   divisor;
    int unsigned       k;
    bit                prime;
    prime = 1'b1;
    if (value < SIEVE_LIMIT) begin
      prime = small_flags[value];
    end else begin
      for (k = 0; k < stored_count; k++) begin
        divisor = 64'(stored_primes[k]);
        if (divisor * divisor > value) break;
        if (value % divisor == 0) begin
          prime = 1'b0;
          break;
        end
      end
    end
    if (prime && prime_tally != TALLY_MAX) prime_tally++;
    verdict.is_prime = prime;
    verdict.total    = prime_tally;
    return verdict;
  endfunction

  // Offers one item after an idle gap and returns at the edge where it is taken.
  // Inputs are read straight after the edge, so they still hold their pre-edge values.
  task automatic offer_value(input logic [VALUE_W-1:0] value, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Idle draw for either side; every third stretch of twelve items runs with no gaps.
  function automatic int idle_draw(input int n);
    return ((n / 12) % 3 == 1) ? 0 : $urandom_range(0, 19);
  endfunction

  // Stimulus and final verdict.
  initial begin
    logic [VALUE_W-1:0] value;
    verdict_t           verdict;
    int                 band;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      offer_value(DIRECTED_ROWS[r].value, idle_draw(r));
      verdict = predict_primality(DIRECTED_ROWS[r].value);
      if (DIRECTED_ROWS[r].typed) begin
        verdict.is_prime = DIRECTED_ROWS[r].is_prime;
        verdict.total    = DIRECTED_ROWS[r].total;
      end
      pending_verdicts.push_back(verdict);
    end

    // Most random values are cheap lookups or modest trial divisions; a few reach up to
    // the full 27 bits, where a prime costs the whole stored list.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      band = $urandom_range(0, 19);
      if (band < 11)      value = VALUE_W'($urandom_range(0, SIEVE_LIMIT - 1));
      else if (band < 17) value = VALUE_W'($urandom_range(SIEVE_LIMIT, 1_000_000));
      else if (band < 19) value = VALUE_W'($urandom_range(1_000_001, 100_000_000));
      else                value = VALUE_W'($urandom());
      offer_value(value, idle_draw(NUM_ROWS + i));
      pending_verdicts.push_back(predict_primality(value));
    end
    in_valid <= 1'b0;

    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: draws an idle gap per item, and early in the directed part, where every
  // value is a quick lookup, it holds off for a long stretch so that the block fills up
  // and drops in_ready.
  initial begin
    int taken;
    int stall;
    taken = 0;
    @(posedge rst_n);
    forever begin
      stall = (taken == HOLD_AT) ? HOLD_OFF : idle_draw(taken);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: is_prime %0d, prime_total %0d",
               out_is_prime, out_prime_total);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_is_prime !== want.is_prime) begin
          $error("is_prime: expected %0d, got %0d", want.is_prime, out_is_prime);
          mismatches++;
        end
        if (out_prime_total !== want.total) begin
          $error("prime_total: expected %0d, got %0d", want.total, out_prime_total);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sieve_backed_primality_tester_core.f =====
design/sbpt_pkg.sv
design/sbpt_sieve.sv
design/sbpt_div.sv
design/sieve_backed_primality_tester_core.sv
tb/sv/tb.sv
